// ===== rtl/aes128_pkg.sv =====
package aes128_pkg;

    localparam int BlockBits = 128;
    localparam int NumRounds = 10;

    // APB register map (64-bit registers at 8-byte spacing).
    localparam logic [3:0] AddrKeyHigh = 4'h0;
    localparam logic [3:0] AddrKeyLow  = 4'h8;

    typedef logic [BlockBits-1:0] t_block;

    // Forward S-box.
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Round constants for rounds 1 to 10.
    localparam logic [7:0] RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // Byte n of a block sits in bits 127-8n downto 120-8n.
    function automatic logic [7:0] get_byte(input t_block b, input int n);
        get_byte = b[BlockBits-1-8*n -: 8];
    endfunction

    // SubBytes followed by ShiftRows.
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlockBits-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
        end
        sub_shift = t;
    endfunction

    function automatic t_block mix(input t_block s);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix = t;
    endfunction

    // Next round key from the previous one.
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        t_block       n;
        logic [31:0]  t;
        t = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
             SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        n[127:96] = k[127:96] ^ t;
        n[95:64]  = k[95:64]  ^ n[127:96];
        n[63:32]  = k[63:32]  ^ n[95:64];
        n[31:0]   = k[31:0]   ^ n[63:32];
        next_key = n;
    endfunction

endpackage

// ===== rtl/aes128_block_encrypt_unit.sv =====
// AES-128 encryption pipeline, one 16-byte block per transfer.
//
// Input stream: s_axis_tdata carries the plaintext, output stream
// m_axis_tdata the ciphertext, both with byte 0 in bits 63 to 56.
// The user writes the key through the APB port (key_high 0x0, key_low 0x8)
// only with no block in flight (not enforced); both halves reset to zero.
//
// Eleven register stages: the initial key addition, then one stage per
// round. The round key is expanded alongside the data in every round
// stage, so a block carries its own key schedule. o_m_axis_tvalid rises
// once a block reaches the final stage; throughput is one block per
// cycle while the output is not stalled.
//
// A stall on the output freezes the whole pipeline; the input ready is
// high whenever the final stage is empty or being drained, so nothing is
// lost or repeated. Synchronous reset empties all stages.
module aes128_block_encrypt_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [63:0] plain_high, [127:64] plain_low
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [63:0] cipher_high, [127:64] cipher_low
    output logic [127:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import aes128_pkg::*;

    localparam int Stages = NumRounds + 1;

    logic [63:0]  r_key_high, r_key_low;
    t_block       r_data [Stages];
    t_block       r_rkey [Stages];
    logic         r_vld  [Stages];
    logic         adv;
    t_block       in_blk;

    assign pready = 1'b1;
    assign prdata = (paddr == AddrKeyLow) ? r_key_low : r_key_high;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == AddrKeyHigh) r_key_high <= pwdata;
            else if (paddr == AddrKeyLow) r_key_low <= pwdata;
        end
    end

    // Whole pipeline moves when the last stage is empty or drained.
    assign adv             = !r_vld[Stages-1] || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign in_blk          = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Stages; i++) r_vld[i] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int i = 1; i < Stages; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // Data and key schedule stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data[0] <= in_blk ^ {r_key_high, r_key_low};
            r_rkey[0] <= {r_key_high, r_key_low};
            for (int i = 1; i < Stages; i++) begin
                r_rkey[i] <= next_key(r_rkey[i-1], RCON[i-1]);
                if (i == Stages-1)
                    r_data[i] <= sub_shift(r_data[i-1])
                                 ^ next_key(r_rkey[i-1], RCON[i-1]);
                else
                    r_data[i] <= mix(sub_shift(r_data[i-1]))
                                 ^ next_key(r_rkey[i-1], RCON[i-1]);
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[Stages-1];
    assign o_m_axis_tdata  = {r_data[Stages-1][63:0], r_data[Stages-1][127:64]};

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output changed under stall");

    // A transfer in reaches stage one on the next edge.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted block lost");

    // Ready follows the last stage.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("ready low with empty output");

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes128_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 16;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // [63:0] plain_high, [127:64] plain_low
    logic [127:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // [63:0] cipher_high, [127:64] cipher_low
    logic [127:0] o_m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    // Key as the block sees it, and ciphertexts still to come back.
    logic [63:0]  key_high_q = '0;
    logic [63:0]  key_low_q = '0;
    t_block       cipher_queue[$];
    int           mismatches = 0;
    int           blocks_sent = 0;
    int           blocks_checked = 0;
    int           key_writes = 0;
    int           cycle_count = 0;
    bit           steady_stream = 1'b0;

    aes128_block_encrypt_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Byte n of a block lives in bits 127-8n downto 120-8n.
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_block aes_encrypt(input t_block key, input t_block plain);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] w[4];
        logic [7:0] first, rc, a0, a1, a2, a3, all;
        t_block     res;
        rc = 8'h01;
        for (int n = 0; n < 16; n++) begin
            rk[n] = key[127-8*n -: 8];
            st[n] = plain[127-8*n -: 8] ^ rk[n];
        end
        // Key schedule: RotWord, SubWord and the round constant every fourth word.
        for (int k = 4; k < 44; k++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[4*(k-1)+j];
            if (k % 4 == 0) begin
                first = w[0];
                w[0] = SBOX[w[1]] ^ rc;
                w[1] = SBOX[w[2]];
                w[2] = SBOX[w[3]];
                w[3] = SBOX[first];
                rc = gf_double(rc);
            end
            for (int j = 0; j < 4; j++) rk[4*k+j] = rk[4*(k-4)+j] ^ w[j];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r+4*c] = SBOX[st[r+4*((c+r)%4)]];
            st = tmp;
            // The last round skips the column mixing.
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    st[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    st[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    st[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int n = 0; n < 16; n++) st[n] = st[n] ^ rk[16*rnd+n];
        end
        for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Output checker: handshake seen at the falling edge completes at the next rising one.
    always @(negedge i_clk) begin
        t_block want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cipher_queue.size() == 0) begin
                report_mismatch("unexpected ciphertext", o_m_axis_tdata[63:0], '0);
            end else begin
                want = cipher_queue.pop_front();
                blocks_checked++;
                if (o_m_axis_tdata[63:0] !== want[127:64])
                    report_mismatch("cipher_high", o_m_axis_tdata[63:0], want[127:64]);
                if (o_m_axis_tdata[127:64] !== want[63:0])
                    report_mismatch("cipher_low", o_m_axis_tdata[127:64], want[63:0]);
            end
        end
    end

    // Output side: random stall before each transfer, none while streaming steadily.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = steady_stream ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            forever begin
                @(negedge i_clk);
                if (o_m_axis_tvalid) break;
            end
            @(posedge i_clk);
        end
    end

    // One plaintext transfer, after a random gap except while streaming steadily.
    task automatic send_block(input logic [63:0] plain_high, input logic [63:0] plain_low);
        int gap;
        gap = steady_stream ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {plain_low, plain_high};
        forever begin
            @(negedge i_clk);
            if (o_s_axis_tready) break;
        end
        @(posedge i_clk);
        cipher_queue.push_back(aes_encrypt({key_high_q, key_low_q}, {plain_high, plain_low}));
        blocks_sent++;
    endtask

    task automatic send_random_block();
        send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Stop sending and let every block in flight come out.
    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== value) report_mismatch("key read back", prdata, value);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == AddrKeyHigh) key_high_q = value;
        else key_low_q = value;
        key_writes++;
    endtask

    task automatic load_key(input logic [63:0] high, input logic [63:0] low);
        write_key_reg(AddrKeyHigh, high);
        write_key_reg(AddrKeyLow, low);
    endtask

    // The reset key of all zeros with plaintext extremes.
    task automatic test_reset_key();
        send_block('0, '0);
        send_block('1, '1);
        send_block('1, '0);
        drain_pipeline();
    endtask

    // The published example vectors.
    task automatic test_known_vectors();
        load_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
        send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
        drain_pipeline();
        load_key(64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C);
        send_block(64'h3243F6A8885A308D, 64'h313198A2E0370734);
        drain_pipeline();
    endtask

    // All-ones key with walking single bits in each plaintext half.
    task automatic test_key_extremes();
        load_key('1, '1);
        for (int b = 0; b < 64; b += 7) send_block(64'd1 << b, '1);
        for (int b = 3; b < 64; b += 9) send_block('0, 64'd1 << b);
        send_block('0, '0);
        drain_pipeline();
    endtask

    // Random plaintext under a sequence of keys, extremes among them.
    task automatic test_random_blocks();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: load_key('0, '0);
                1: load_key('1, '1);
                2: load_key('0, '1);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            steady_stream = (phase % 3 == 2);
            for (int n = 0; n < 108; n++) begin
                send_random_block();
                // Halfway through one phase, hold off until the pipeline is empty.
                if (phase == 4 && n == 54) drain_pipeline();
            end
            steady_stream = 1'b0;
            drain_pipeline();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_known_vectors();
        test_key_extremes();
        test_random_blocks();
        $display("Encrypted %0d blocks under %0d key register writes, %0d ciphertexts checked.",
                 blocks_sent, key_writes, blocks_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
